// ===== hw/rtl/scpa_pkg.sv =====
// Package: constants, item types, controller/datapath interface types and carve/page helper functions.
`default_nettype none
package scpa_pkg;
  localparam int NUM_PAGES    = 64;
  localparam int PAGE_BYTES   = 4096;
  localparam int NUM_CLASSES  = 12;
  localparam int WORD_BYTES   = 8;
  localparam int PAGE_WORDS   = PAGE_BYTES / WORD_BYTES;
  localparam int PAGE_SHIFT   = $clog2(PAGE_WORDS);
  localparam int REGION_WORDS = NUM_PAGES * PAGE_WORDS;
  localparam int ADDR_W       = 15;
  localparam int PAGE_W       = $clog2(NUM_PAGES);
  localparam int PCNT_W       = 7;
  localparam int CLS_W        = 4;
  localparam int LEFT_W       = 10;
  localparam int HEAD_W       = 16;
  localparam int BYTES_W      = 15;
  localparam int SIZE_W       = 16;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TOO_BIG  = 2'd1;
  localparam logic [1:0] ST_NO_PAGES = 2'd2;
  localparam logic [1:0] ST_UNOWNED  = 2'd3;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0] free_addr;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ADDR_W-1:0]  block_addr;
    logic [BYTES_W-1:0] block_bytes;
  } rsp_t;

  typedef struct packed {
    logic load_req;
    logic commit_look;
    logic commit_pop;
    logic rd_en;
  } cmd_t;

  typedef struct packed {
    logic need_pop;
    logic out_free;
  } sts_t;

  function automatic logic [LEFT_W-1:0] carve_count(input logic [CLS_W-1:0] c);
    int w;
    w = PAGE_WORDS >> c;
    if (w == 0) w = 1;
    return LEFT_W'(w);
  endfunction

  function automatic logic [PCNT_W:0] pages_needed(input logic [CLS_W-1:0] c);
    int w;
    w = ((1 << c) + PAGE_WORDS - 1) >> PAGE_SHIFT;
    return (PCNT_W + 1)'(w);
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/scpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module scpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/scpa_ctrl.sv =====
// Controller state machine: accept, look up, optional list pop, result load.
`default_nettype none
module scpa_ctrl import scpa_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output      logic in_stall,
  input  wire sts_t sts,
  output      cmd_t cmd
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_POP  = 3'b100
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (sts.need_pop) begin
          cmd.rd_en = 1'b1;
          state_next = S_POP;
        end else if (sts.out_free) begin
          cmd.commit_look = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_POP: begin
        if (sts.out_free) begin
          cmd.commit_pop = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/scpa_dp.sv =====
// Datapath: class lookup, free lists, carve state, page table, link memory, result register.
`default_nettype none
module scpa_dp import scpa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [PCNT_W-1:0] cfg_wr_data,
  input  wire req_t              in_item,
  input  wire cmd_t              cmd,
  output      sts_t              sts,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      rsp_t              out_item
);
  logic [PCNT_W-1:0] page_limit;
  logic [PCNT_W-1:0] pages_used;
  req_t              req;
  logic [HEAD_W-1:0] free_heads [NUM_CLASSES];
  logic [ADDR_W-1:0] carve_next [NUM_CLASSES];
  logic [LEFT_W-1:0] carve_left [NUM_CLASSES];
  logic [NUM_PAGES-1:0] page_owned;

  logic [CLS_W-1:0]   cls_a, cls_f, cls;
  logic               too_large;
  logic [PCNT_W-1:0]  lim;
  logic [PCNT_W:0]    need_sum;
  logic               claim, oom, f_bad;
  logic [PAGE_W-1:0]  f_page;
  logic [CLS_W-1:0]   f_pc;
  logic [CLS_W-1:0]   pc_rd;
  logic               pc_we;
  logic [BYTES_W-1:0] cls_bytes;
  logic [ADDR_W-1:0]  blk;
  logic [LEFT_W-1:0]  left_base;
  logic [HEAD_W-1:0]  head;
  logic               head_ok;
  logic [HEAD_W-1:0]  link_rd;
  logic               ram_we;
  rsp_t               look_rsp;

  always_comb begin
    cls_a = '0;
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if ({1'b0, req.req_size} <= 17'(WORD_BYTES << i)) cls_a = CLS_W'(i);
    end
    too_large = {1'b0, req.req_size} > 17'(WORD_BYTES << (NUM_CLASSES - 1));
  end

  assign f_page = req.free_addr[ADDR_W-1:PAGE_SHIFT];
  assign f_pc   = page_owned[f_page] ? pc_rd : '0;
  assign f_bad  = (f_pc == '0) || ({1'b0, f_pc} > (CLS_W + 1)'(NUM_CLASSES));
  assign cls_f  = f_pc - CLS_W'(1);
  assign cls    = (req.mode == MODE_FREE) ? cls_f : cls_a;
  assign cls_bytes = BYTES_W'(WORD_BYTES << cls);

  assign head    = free_heads[cls_a];
  assign head_ok = head[HEAD_W-1];
  assign lim     = (page_limit > PCNT_W'(NUM_PAGES)) ? PCNT_W'(NUM_PAGES) : page_limit;
  assign claim   = (carve_left[cls_a] == '0);
  assign need_sum = {1'b0, pages_used} + pages_needed(cls_a);
  assign oom     = claim && (need_sum > {1'b0, lim});
  assign blk     = claim ? ADDR_W'({pages_used, {PAGE_SHIFT{1'b0}}}) : carve_next[cls_a];
  assign left_base = claim ? carve_count(cls_a) : carve_left[cls_a];

  assign sts.need_pop = (req.mode == MODE_ALLOC) && !too_large && head_ok;
  assign sts.out_free = !out_valid || !out_stall;

  always_comb begin
    look_rsp = '0;
    if (req.mode == MODE_FREE) begin
      if (f_bad) look_rsp.status = ST_UNOWNED;
      else look_rsp.block_bytes = cls_bytes;
    end else if (too_large) begin
      look_rsp.status = ST_TOO_BIG;
    end else if (oom) begin
      look_rsp.status = ST_NO_PAGES;
    end else begin
      look_rsp.block_addr  = blk;
      look_rsp.block_bytes = cls_bytes;
    end
  end

  assign ram_we = cmd.commit_look && (req.mode == MODE_FREE) && !f_bad;
  assign pc_we  = cmd.commit_look && (req.mode == MODE_ALLOC) && !too_large && !oom && claim;

  scpa_ram #(.WIDTH(HEAD_W), .DEPTH(REGION_WORDS)) u_link (
    .clk   (clk),
    .we    (ram_we),
    .waddr (req.free_addr),
    .wdata (free_heads[cls_f]),
    .re    (cmd.rd_en),
    .raddr (head[ADDR_W-1:0]),
    .rdata (link_rd)
  );

  scpa_ram #(.WIDTH(CLS_W), .DEPTH(NUM_PAGES)) u_page (
    .clk   (clk),
    .we    (pc_we),
    .waddr (pages_used[PAGE_W-1:0]),
    .wdata (cls_a + CLS_W'(1)),
    .re    (cmd.load_req),
    .raddr (in_item.free_addr[ADDR_W-1:PAGE_SHIFT]),
    .rdata (pc_rd)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_req) req <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_limit <= PCNT_W'(64);
      pages_used <= '0;
      out_valid  <= 1'b0;
      page_owned <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        free_heads[i] <= '0;
        carve_next[i] <= '0;
        carve_left[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) page_limit <= cfg_wr_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.commit_pop) begin
        free_heads[cls_a] <= link_rd;
        out_valid <= 1'b1;
      end
      if (cmd.commit_look) begin
        out_valid <= 1'b1;
        if (req.mode == MODE_FREE) begin
          if (!f_bad) free_heads[cls_f] <= {1'b1, req.free_addr};
        end else if (!too_large && !oom) begin
          if (claim) begin
            page_owned[pages_used[PAGE_W-1:0]] <= 1'b1;
            pages_used <= need_sum[PCNT_W-1:0];
          end
          carve_next[cls_a] <= blk + ADDR_W'(1 << cls_a);
          carve_left[cls_a] <= left_base - LEFT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_look) out_item <= look_rsp;
    if (cmd.commit_pop) out_item <= '{status: ST_OK, block_addr: head[ADDR_W-1:0],
                                      block_bytes: cls_bytes};
  end
endmodule
`default_nettype wire

// ===== hw/rtl/size_class_pool_allocator_top.sv =====
// Top level of the size-class pool allocator.
// Request channel in_valid/in_stall/in_item carries allocate or free items;
// result channel out_valid/out_stall/out_item returns one item per request.
// cfg_wr_en/cfg_wr_data write page_limit; write only while the block is idle.
// An item is taken in the idle state and looked up in the lookup state: a free,
// a carve, a fresh page claim or an error finishes there. An allocate served
// from a free list goes on to a pop state for the registered read of the link
// word memory.
// The result sits in an output register; the next request is accepted while
// it waits. If the receiver stalls and the register still holds an item,
// the following request waits in its lookup or pop state until the register drains.
// Reset empties all free lists, clears the page table and carve state,
// sets the bump pointer to zero and page_limit to 64. No clearing pass is
// needed; the link memory is only read at addresses a free has written.
`default_nettype none
module size_class_pool_allocator_top import scpa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [PCNT_W-1:0] cfg_wr_data,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire req_t              in_item,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      rsp_t              out_item
);
  cmd_t cmd;
  sts_t sts;

  scpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  scpa_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_item     (in_item),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for the size-class pool allocator: directed table, page-limit tests, then random traffic.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import scpa_pkg::*;

  localparam int WATCHDOG = 20000;

  typedef struct {
    req_t req;
    logic has_rsp;
    rsp_t rsp;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [PCNT_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_item;

  size_class_pool_allocator_top u_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // allocator shadow state
  int unsigned lim_pages;
  logic [HEAD_W-1:0] heads[NUM_CLASSES];
  logic [HEAD_W-1:0] links[REGION_WORDS];
  logic [CLS_W-1:0] owner[NUM_PAGES];
  int unsigned used_pages;
  int unsigned next_blk[NUM_CLASSES];
  int unsigned blks_left[NUM_CLASSES];

  rsp_t rsp_queue[$];
  logic [ADDR_W-1:0] live_blocks[$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  bit hold_off = 1'b0;

  function automatic rsp_t allocate_or_free(req_t r);
    rsp_t o;
    int unsigned c, n, need, lim, pg, blk;
    o = '0;
    if (r.mode == MODE_ALLOC) begin
      c = 0;
      n = WORD_BYTES;
      while (n < r.req_size && c < NUM_CLASSES) begin
        c++;
        n <<= 1;
      end
      if (c >= NUM_CLASSES) begin
        o.status = ST_TOO_BIG;
        return o;
      end
      if (heads[c][15]) begin
        blk = heads[c][14:0];
        heads[c] = links[blk];
      end else begin
        if (blks_left[c] == 0) begin
          need = (n + PAGE_BYTES - 1) / PAGE_BYTES;
          lim = lim_pages < NUM_PAGES ? lim_pages : NUM_PAGES;
          if (used_pages + need > lim) begin
            o.status = ST_NO_PAGES;
            return o;
          end
          owner[used_pages] = CLS_W'(c + 1);
          next_blk[c] = used_pages * PAGE_WORDS;
          blks_left[c] = (need * PAGE_BYTES) / n;
          used_pages += need;
        end
        blk = next_blk[c];
        next_blk[c] += 1 << c;
        blks_left[c]--;
      end
      o.status = ST_OK;
      o.block_addr = ADDR_W'(blk);
      o.block_bytes = BYTES_W'(n);
    end else begin
      pg = r.free_addr / PAGE_WORDS;
      if (pg >= NUM_PAGES || owner[pg] == 0) begin
        o.status = ST_UNOWNED;
        return o;
      end
      c = owner[pg] - 1;
      links[r.free_addr] = heads[c];
      heads[c] = {1'b1, r.free_addr};
      o.status = ST_OK;
      o.block_bytes = BYTES_W'(WORD_BYTES << c);
    end
    return o;
  endfunction

  task automatic reset_model();
    lim_pages = 64;
    used_pages = 0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      heads[i] = '0;
      next_blk[i] = 0;
      blks_left[i] = 0;
    end
    for (int i = 0; i < NUM_PAGES; i++) owner[i] = '0;
  endtask

  // predict the result, check it against any typed result and queue it; track live blocks for frees
  task automatic predict(req_t r, logic has_rsp, rsp_t typed);
    rsp_t p;
    p = allocate_or_free(r);
    if (has_rsp && p != typed) begin
      errors++;
      if (errors <= 10)
        $display("table mismatch: typed %h predicted %h", typed, p);
    end
    if (r.mode == MODE_ALLOC && p.status == ST_OK) live_blocks.push_back(p.block_addr);
    rsp_queue.push_back(p);
  endtask

  task automatic send(req_t r, logic has_rsp, rsp_t typed);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_item <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict(r, has_rsp, typed);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (rsp_queue.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_limit(int unsigned v);
    cfg_wr_data <= PCNT_W'(v);
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    lim_pages = v;
  endtask

  function automatic req_t mk(logic m, int unsigned sz, int unsigned fa);
    req_t r;
    r.mode = m;
    r.req_size = SIZE_W'(sz);
    r.free_addr = ADDR_W'(fa);
    return r;
  endfunction

  function automatic rsp_t rs(logic [1:0] s, int unsigned a, int unsigned b);
    rsp_t o;
    o.status = s;
    o.block_addr = ADDR_W'(a);
    o.block_bytes = BYTES_W'(b);
    return o;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int unsigned k;
    k = $urandom_range(0, 99);
    r = '0;
    r.req_size = SIZE_W'($urandom);
    r.free_addr = ADDR_W'($urandom);
    if (k < 50) begin
      r.mode = MODE_ALLOC;
      if (k < 40) r.req_size = SIZE_W'($urandom_range(0, 8) == 0 ?
                                       $urandom_range(0, 16384) :
                                       $urandom_range(0, 512));
    end else begin
      r.mode = MODE_FREE;
      if (k < 85 && live_blocks.size() != 0) begin
        k = $urandom_range(0, live_blocks.size() - 1);
        r.free_addr = live_blocks[k];
        live_blocks.delete(k);
      end
    end
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (!rst && out_valid && !out_stall) begin
      idle_cycles <= 0;
      if (rsp_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item %h", out_item);
      end else begin
        exp_rsp = rsp_queue.pop_front();
        if (out_item.status !== exp_rsp.status ||
            out_item.block_addr !== exp_rsp.block_addr ||
            out_item.block_bytes !== exp_rsp.block_bytes) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %0d/%h/%0d actual %0d/%h/%0d",
                     exp_rsp.status, exp_rsp.block_addr, exp_rsp.block_bytes,
                     out_item.status, out_item.block_addr, out_item.block_bytes);
        end
      end
    end else if (!rst && !(in_valid && !in_stall)) begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver stalls
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (200) @(negedge clk);
        out_stall <= 1'b0;
        hold_off = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    @(posedge clk);
    while (idle_cycles < WATCHDOG) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  initial begin
    row_t tbl[$];
    tbl = '{
      '{mk(MODE_FREE, 0, 0), 1'b1, rs(ST_UNOWNED, 0, 0)},
      '{mk(MODE_ALLOC, 0, 0), 1'b1, rs(ST_OK, 0, 8)},
      '{mk(MODE_ALLOC, 8, 0), 1'b1, rs(ST_OK, 1, 8)},
      '{mk(MODE_ALLOC, 9, 0), 1'b1, rs(ST_OK, 512, 16)},
      '{mk(MODE_ALLOC, 16385, 0), 1'b1, rs(ST_TOO_BIG, 0, 0)},
      '{mk(MODE_ALLOC, 65535, 32767), 1'b1, rs(ST_TOO_BIG, 0, 0)},
      '{mk(MODE_ALLOC, 16384, 0), 1'b0, '0},
      '{mk(MODE_FREE, 65535, 1), 1'b1, rs(ST_OK, 0, 8)},
      '{mk(MODE_FREE, 0, 0), 1'b1, rs(ST_OK, 0, 8)},
      '{mk(MODE_ALLOC, 1, 0), 1'b1, rs(ST_OK, 0, 8)},
      '{mk(MODE_ALLOC, 2, 0), 1'b1, rs(ST_OK, 1, 8)},
      '{mk(MODE_ALLOC, 3, 0), 1'b1, rs(ST_OK, 2, 8)},
      '{mk(MODE_FREE, 0, 1536), 1'b1, rs(ST_UNOWNED, 0, 0)},
      '{mk(MODE_FREE, 0, 32767), 1'b1, rs(ST_UNOWNED, 0, 0)},
      '{mk(MODE_FREE, 0, 515), 1'b0, '0},
      '{mk(MODE_ALLOC, 4096, 0), 1'b0, '0},
      '{mk(MODE_ALLOC, 2048, 0), 1'b0, '0},
      '{mk(MODE_ALLOC, 10, 0), 1'b0, '0}
    };
    reset_model();
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (tbl[i]) send(tbl[i].req, tbl[i].has_rsp, tbl[i].rsp);
    drain();
    // exhaust a small limit, then restore
    set_limit(7);
    for (int i = 0; i < 6; i++) send(mk(MODE_ALLOC, 16384, 0), 1'b0, '0);
    send(mk(MODE_ALLOC, 32 << 5, 0), 1'b0, '0);
    drain();
    set_limit(1);
    send(mk(MODE_ALLOC, 16384, 0), 1'b1, rs(ST_NO_PAGES, 0, 0));
    drain();
    set_limit(0);
    send(mk(MODE_ALLOC, 4000, 0), 1'b0, '0);
    drain();
    set_limit(127);
    hold_off = 1'b1;
    for (int i = 0; i < 40; i++) send(rand_req(), 1'b0, '0);
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      set_limit(ph == 3 ? 64 : $urandom_range(1, 127));
      if (ph == 3) quiet = 1'b1;
      for (int i = 0; i < 240; i++) send(rand_req(), 1'b0, '0);
    end
    drain();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/scpa_pkg.sv
hw/rtl/scpa_ram.sv
hw/rtl/scpa_ctrl.sv
hw/rtl/scpa_dp.sv
hw/rtl/size_class_pool_allocator_top.sv
tb/testbench.sv
